[design/rc4s_pkg.sv]
// Shared types and constants for the RC4 stream cipher unit.
// Used by rc4s_perm_engine and rc4_stream_cipher_unit; depends on nothing.
`default_nettype none

package rc4s_pkg;

  // Key store and register widths
  localparam int MAX_KEY_BYTES_DEF = 512;
  localparam int KEY_LEN_W         = 10;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 10;

  localparam logic [KEY_LEN_W-1:0] KEY_MIN_RESET = 10'd40;
  localparam logic [KEY_LEN_W-1:0] KEY_MAX_RESET = 10'd512;
  localparam logic [KEY_LEN_W-1:0] COUNT_CAP     = 10'd1023;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MAX = 1'b1;

  // Input item kinds
  typedef enum logic [1:0] {
    MODE_KEY     = 2'd0,
    MODE_DATA    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_KEY_OK     = 2'd1,
    STAT_KEY_REJECT = 2'd2,
    STAT_NO_KEY     = 2'd3
  } status_t;

  // Permutation engine operations
  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_STREAM   = 1'b1
  } eng_op_t;

  // Permutation engine sequencer states
  typedef enum logic [3:0] {
    ENG_IDLE,
    ENG_INIT,
    ENG_KRN,
    ENG_KRJ,
    ENG_KWN,
    ENG_KWJ,
    ENG_SRI,
    ENG_SRJ,
    ENG_SW,
    ENG_SW2
  } eng_state_t;

  // Top-level control states
  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_BUSY,
    TOP_FINISH
  } top_state_t;

  // Request from the top level to the engine
  typedef struct packed {
    logic                 start;
    eng_op_t              op;
    logic [KEY_LEN_W-1:0] key_len;
  } eng_req_t;

  // Response from the engine to the top level
  typedef struct packed {
    logic       done;
    logic [7:0] ks_byte;
  } eng_rsp_t;

endpackage

`default_nettype wire

[design/rc4s_perm_engine.sv]
// Permutation table and its sequencer: key schedule and keystream generation.
// Depends on rc4s_pkg; reads key bytes through the owner's key store port.
`default_nettype none

module rc4s_perm_engine (
  input  logic                     clk,
  input  logic                     rst,
  input  rc4s_pkg::eng_req_t       req,
  input  logic [7:0]               key_data,
  output logic [rc4s_pkg::KEY_LEN_W-1:0] key_idx,
  output rc4s_pkg::eng_rsp_t       rsp
);
  import rc4s_pkg::*;

  eng_state_t state, state_next;

  // Permutation memory with one write port and a registered read port
  logic [7:0] perm_mem [256];
  logic [7:0] perm_rdata;
  logic       perm_we;
  logic [7:0] perm_waddr;
  logic [7:0] perm_wdata;
  logic [7:0] perm_raddr;

  // Stream indices, loop counters and temporaries
  logic [7:0]           i;
  logic [7:0]           j;
  logic [7:0]           n;
  logic [7:0]           si;
  logic [7:0]           sj;
  logic [7:0]           t;
  logic [7:0]           ks_byte;
  logic                 done;
  logic [KEY_LEN_W-1:0] kidx;
  logic [KEY_LEN_W-1:0] klen;

  logic [7:0]           j_sched;
  logic [7:0]           j_stream;
  logic [KEY_LEN_W-1:0] kidx_next;
  logic [7:0]           ks_sel;
  logic                 last_n;

  assign j_sched   = j + perm_rdata + key_data;
  assign j_stream  = j + perm_rdata;
  assign kidx_next = (kidx + 1'b1 == klen) ? '0 : kidx + 1'b1;
  assign last_n    = (n == 8'hFF);
  // Bypass the entries just swapped, since the read saw them before the write
  assign ks_sel    = (t == i) ? sj : ((t == j) ? si : perm_rdata);

  assign key_idx     = kidx;
  assign rsp.done    = done;
  assign rsp.ks_byte = ks_byte;

  // Hold the permutation memory
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rdata <= perm_mem[perm_raddr];
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ENG_SW2) || ((state == ENG_KWJ) && last_n);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: begin
        if (req.start) begin
          state_next = (req.op == OP_STREAM) ? ENG_SRI : ENG_INIT;
        end
      end
      ENG_INIT: begin
        if (last_n) state_next = ENG_KRN;
      end
      ENG_KRN: state_next = ENG_KRJ;
      ENG_KRJ: state_next = ENG_KWN;
      ENG_KWN: state_next = ENG_KWJ;
      ENG_KWJ: state_next = last_n ? ENG_IDLE : ENG_KRN;
      ENG_SRI: state_next = ENG_SRJ;
      ENG_SRJ: state_next = ENG_SW;
      ENG_SW:  state_next = ENG_SW2;
      ENG_SW2: state_next = ENG_IDLE;
      default: state_next = ENG_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    perm_we    = 1'b0;
    perm_waddr = n;
    perm_wdata = n;
    perm_raddr = i;
    unique case (state)
      ENG_INIT: begin
        perm_we = 1'b1;
      end
      ENG_KRN: perm_raddr = n;
      ENG_KRJ: perm_raddr = j_sched;
      ENG_KWN: begin
        perm_we    = 1'b1;
        perm_wdata = perm_rdata;
      end
      ENG_KWJ: begin
        perm_we    = 1'b1;
        perm_waddr = j;
        perm_wdata = si;
      end
      ENG_SRJ: perm_raddr = j_stream;
      ENG_SW: begin
        perm_we    = 1'b1;
        perm_waddr = i;
        perm_wdata = perm_rdata;
        perm_raddr = si + perm_rdata;
      end
      ENG_SW2: begin
        perm_we    = 1'b1;
        perm_waddr = j;
        perm_wdata = si;
      end
      default: perm_raddr = i;
    endcase
  end

  // Update indices and temporaries
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else begin
      case (state)
        ENG_IDLE: begin
          if (req.start) begin
            if (req.op == OP_STREAM) begin
              i <= i + 8'd1;
            end else begin
              n    <= '0;
              kidx <= '0;
              klen <= req.key_len;
              j    <= '0;
            end
          end
        end
        ENG_INIT: n <= n + 8'd1;
        ENG_KRJ: begin
          si <= perm_rdata;
          j  <= j_sched;
        end
        ENG_KWJ: begin
          n    <= n + 8'd1;
          kidx <= kidx_next;
          if (last_n) begin
            i <= '0;
            j <= '0;
          end
        end
        ENG_SRJ: begin
          si <= perm_rdata;
          j  <= j_stream;
        end
        ENG_SW: begin
          sj <= perm_rdata;
          t  <= si + perm_rdata;
        end
        ENG_SW2: ks_byte <= ks_sel;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/rc4_stream_cipher_unit.sv]
// RC4 stream cipher unit: stream ports, configuration registers, key store.
// Depends on rc4s_pkg and rc4s_perm_engine.
`default_nettype none

// One item is taken at a time. A key byte that needs no key schedule is
// answered without the engine; a data byte takes four permutation-memory
// steps plus hand-off to the output register; an accepted final key byte or a
// restart runs the key schedule: a fill of all 256 table entries, then four
// steps for each of the 256 mixing steps. These step counts are set by the
// permutation memory, whose one read port and one write port carry every
// table read and write. Items that report no valid key or a rejected length
// do not start the engine. Results wait in an output register, so a new item
// can be taken while the previous result is still pending. Key bytes beyond
// MAX_KEY_BYTES are not stored, and such a key is rejected on its last byte.
module rc4_stream_cipher_unit #(
  parameter int MAX_KEY_BYTES = rc4s_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [rc4s_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rc4s_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] byte_in
  input  logic [1:0]                       s_tuser,   // [1:0] mode
  input  logic                             s_tlast,   // last key byte
  // Output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // [7:0] byte_out
  output logic [1:0]                       m_tuser    // [1:0] status
);
  import rc4s_pkg::*;

  localparam int KEY_DEPTH = 2 * MAX_KEY_BYTES;
  localparam int KA_W      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LEN_W     = KEY_LEN_W + 1;

  localparam logic [KA_W-1:0]  BANK_BASE = KA_W'(MAX_KEY_BYTES);
  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_KEY_BYTES);

  top_state_t state, state_next;

  // Configuration and key bookkeeping
  logic [KEY_LEN_W-1:0] key_min;
  logic [KEY_LEN_W-1:0] key_max;
  logic                 active_bank;
  logic [KEY_LEN_W-1:0] key_length;
  logic [KEY_LEN_W-1:0] staging_count;
  logic                 key_valid;

  // Pending result
  logic [7:0] res_byte;
  logic [1:0] res_status;
  logic       pend_stream;
  logic [7:0] pend_data;

  // Key store with registered read
  logic [7:0]      key_mem [KEY_DEPTH];
  logic [7:0]      key_rdata;
  logic            key_we;
  logic [KA_W-1:0] key_waddr;
  logic [KA_W-1:0] key_raddr;

  eng_req_t             eng_req;
  eng_rsp_t             eng_rsp;
  logic [KEY_LEN_W-1:0] eng_key_idx;

  mode_t                in_mode;
  logic                 accept;
  logic                 out_free;
  logic [LEN_W-1:0]     new_len;
  logic                 len_ok;
  logic [KEY_LEN_W-1:0] restart_len;
  status_t              in_status;

  assign in_mode  = mode_t'(s_tuser);
  assign s_tready = (state == TOP_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign new_len = {1'b0, staging_count} + LEN_W'(1);
  assign len_ok  = (new_len >= {1'b0, key_min}) && (new_len <= {1'b0, key_max}) &&
                   (new_len <= MAX_LEN);
  assign restart_len = ((key_length == '0) || ({1'b0, key_length} > MAX_LEN)) ?
                       KEY_LEN_W'(1) : key_length;

  assign key_waddr = KA_W'(staging_count) + (active_bank ? '0 : BANK_BASE);
  assign key_raddr = KA_W'(eng_key_idx) + (active_bank ? BANK_BASE : '0);

  // Hold the key store
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= s_tdata;
    end
    key_rdata <= key_mem[key_raddr];
  end

  rc4s_perm_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .req      (eng_req),
    .key_data (key_rdata),
    .key_idx  (eng_key_idx),
    .rsp      (eng_rsp)
  );

  // Decode the incoming item
  always_comb begin
    key_we          = 1'b0;
    eng_req.start   = 1'b0;
    eng_req.op      = OP_SCHEDULE;
    eng_req.key_len = restart_len;
    in_status       = STAT_OK;
    unique case (in_mode) inside
      MODE_KEY: begin
        key_we          = accept && ({1'b0, staging_count} < MAX_LEN);
        // A length that wraps to zero in the length register schedules as one byte
        eng_req.key_len = (new_len[KEY_LEN_W-1:0] == '0) ? KEY_LEN_W'(1) :
                          new_len[KEY_LEN_W-1:0];
        if (s_tlast) begin
          in_status     = len_ok ? STAT_KEY_OK : STAT_KEY_REJECT;
          eng_req.start = accept && len_ok;
        end
      end
      MODE_DATA, MODE_RESTART: begin
        in_status     = key_valid ? STAT_OK : STAT_NO_KEY;
        eng_req.start = accept && key_valid;
        eng_req.op    = (in_mode == MODE_DATA) ? OP_STREAM : OP_SCHEDULE;
      end
      default: in_status = STAT_OK;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      TOP_IDLE: begin
        if (accept) state_next = eng_req.start ? TOP_BUSY : TOP_FINISH;
      end
      TOP_BUSY: begin
        if (eng_rsp.done) state_next = TOP_FINISH;
      end
      TOP_FINISH: begin
        if (out_free) state_next = TOP_IDLE;
      end
      default: state_next = TOP_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= TOP_IDLE;
      key_min       <= KEY_MIN_RESET;
      key_max       <= KEY_MAX_RESET;
      active_bank   <= 1'b0;
      key_length    <= '0;
      staging_count <= '0;
      key_valid     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_MIN: key_min <= cfg_data;
          CFG_KEY_MAX: key_max <= cfg_data;
          default: ;
        endcase
      end
      // Count key bytes, swap banks on an accepted key
      if (accept && (in_mode == MODE_KEY)) begin
        if (!s_tlast) begin
          if (staging_count != COUNT_CAP) staging_count <= staging_count + 1'b1;
        end else begin
          staging_count <= '0;
          if (len_ok) begin
            active_bank <= ~active_bank;
            key_length  <= new_len[KEY_LEN_W-1:0];
            key_valid   <= 1'b1;
          end
        end
      end
      // Present the result, drop it once taken
      if ((state == TOP_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_byte    <= '0;
      res_status  <= in_status;
      pend_stream <= eng_req.start && (eng_req.op == OP_STREAM);
      pend_data   <= s_tdata;
    end else if ((state == TOP_BUSY) && eng_rsp.done && pend_stream) begin
      res_byte <= pend_data ^ eng_rsp.ks_byte;
    end
    if ((state == TOP_FINISH) && out_free) begin
      m_tdata <= res_byte;
      m_tuser <= res_status;
    end
  end

`ifndef SYNTHESIS
  // The engine only finishes work that this level started
  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    eng_rsp.done |-> (state == TOP_BUSY))
    else $error("engine done outside busy state");

  // A valid key never goes away
  a_key_valid_holds: assert property (@(posedge clk) disable iff (rst)
    key_valid |=> key_valid)
    else $error("key valid dropped");

  // An accepted final key byte swaps banks and starts the schedule
  a_key_swap: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_mode == MODE_KEY) && s_tlast && len_ok) |=>
      ((active_bank != $past(active_bank)) && (state == TOP_BUSY)))
    else $error("accepted key did not swap banks");

  // Items are not taken while the engine is busy
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == TOP_BUSY) |-> !s_tready)
    else $error("ready while busy");
`endif

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for rc4_stream_cipher_unit: key loading, length limits,
// keystream XOR and restart, checked against an in-bench cipher tracker.
// Depends on rc4s_pkg and the rc4_stream_cipher_unit design files.
`default_nettype none

module tb;
  import rc4s_pkg::*;

  localparam int KEY_CAP     = MAX_KEY_BYTES_DEF;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int PHASE_ITEMS = 120;

  // Track the cipher state and the results still owed by the block
  class rc4_cipher_tracker;
    typedef struct packed {
      logic [7:0] data;
      logic [1:0] status;
    } cipher_result_t;

    cipher_result_t results_due[$];
    int             key_min;
    int             key_max;
    logic [7:0]     perm [256];
    logic [7:0]     key_bytes [2*KEY_CAP];
    bit             bank;
    int             key_len;
    int             staged;
    bit             keyed;
    logic [7:0]     idx_i;
    logic [7:0]     idx_j;
    int             errors;
    int             checked;

    function new();
      key_min = KEY_MIN_RESET;
      key_max = KEY_MAX_RESET;
      foreach (perm[n]) perm[n] = '0;
      foreach (key_bytes[n]) key_bytes[n] = '0;
      bank    = 1'b0;
      key_len = 0;
      staged  = 0;
      keyed   = 1'b0;
      idx_i   = '0;
      idx_j   = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_limits(int lo, int hi);
      key_min = lo;
      key_max = hi;
    endfunction

    // Rebuild the permutation from the active key bank
    function void run_key_schedule();
      logic [7:0] j;
      logic [7:0] t;
      int         len;
      j   = '0;
      len = key_len;
      if (len == 0 || len > KEY_CAP) len = 1;
      for (int n = 0; n < 256; n++) perm[n] = 8'(n);
      for (int n = 0; n < 256; n++) begin
        j       = j + perm[n] + key_bytes[int'(bank) * KEY_CAP + (n % len)];
        t       = perm[n];
        perm[n] = perm[j];
        perm[j] = t;
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    // Apply one accepted item and queue the result it causes
    function void note_item(logic [1:0] m, logic [7:0] b, logic l);
      cipher_result_t r;
      logic [7:0]     t;
      logic [7:0]     k;
      bit             spare;
      int             len;
      r.data   = '0;
      r.status = STAT_OK;
      spare    = ~bank;
      case (m)
        MODE_KEY: begin
          len = staged + 1;
          if (staged < KEY_CAP) key_bytes[int'(spare) * KEY_CAP + staged] = b;
          if (!l) begin
            staged = (len > int'(COUNT_CAP)) ? int'(COUNT_CAP) : len;
          end else begin
            staged = 0;
            if (len >= key_min && len <= key_max && len <= KEY_CAP) begin
              bank    = spare;
              key_len = len;
              keyed   = 1'b1;
              run_key_schedule();
              r.status = STAT_KEY_OK;
            end else begin
              r.status = STAT_KEY_REJECT;
            end
          end
        end
        MODE_DATA: begin
          if (!keyed) begin
            r.status = STAT_NO_KEY;
          end else begin
            idx_i       = idx_i + 8'd1;
            idx_j       = idx_j + perm[idx_i];
            t           = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            k           = perm[idx_i] + perm[idx_j];
            r.data      = b ^ perm[k];
          end
        end
        MODE_RESTART: begin
          if (!keyed) r.status = STAT_NO_KEY;
          else run_key_schedule();
        end
        default: ;
      endcase
      results_due.push_back(r);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(logic [7:0] d, logic [1:0] st);
      cipher_result_t e;
      checked++;
      if (results_due.size() == 0) begin
        flag($sformatf("result %0d with none outstanding: byte %02h status %0d",
                       checked, d, st));
        return;
      end
      e = results_due.pop_front();
      if (d !== e.data || st !== e.status)
        flag($sformatf("result %0d: expected byte %02h status %0d, got byte %02h status %0d",
                       checked, e.data, e.status, d, st));
    endfunction

    function int outstanding();
      return results_due.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;   // [7:0] byte_in
  logic [1:0]            s_tuser   = '0;   // [1:0] mode
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [7:0]            m_tdata;          // [7:0] byte_out
  logic [1:0]            m_tuser;          // [1:0] status

  rc4_cipher_tracker tracker;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;
  int phase_items  = 0;
  int cycle_count  = 0;

  rc4_stream_cipher_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rc4_stream_cipher_unit");
      $finish;
    end
  end

  // Check accepted results, then stall or hold off the output side
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) tracker.check_result(m_tdata, m_tuser);
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(logic [1:0] m, logic [7:0] b, logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= m;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk); while (s_tready !== 1'b1);
    tracker.note_item(m, b, l);
    if (m != MODE_NONE) phase_items++;
  endtask

  // Send a key of len bytes, random when fill is negative
  task automatic send_key(int len, int fill);
    for (int n = 0; n < len; n++)
      send_item(MODE_KEY, (fill < 0) ? 8'($urandom_range(255)) : 8'(fill), n == len - 1);
  endtask

  task automatic send_data(int count);
    for (int n = 0; n < count; n++)
      send_item(MODE_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Drop valid and wait until every owed result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic set_limits(int lo, int hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_MIN;
    cfg_data  <= CFG_DATA_W'(lo);
    @(posedge clk);
    cfg_index <= CFG_KEY_MAX;
    cfg_data  <= CFG_DATA_W'(hi);
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_limits(lo, hi);
  endtask

  // Mostly keys followed by data bursts, with restarts and stray items mixed in
  task automatic random_phase(int tx, int rx, int lo, int hi, int hold);
    int len;
    int pick;
    drain();
    set_limits(lo, hi);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    rx_hold      = hold;
    phase_items  = 0;
    while (phase_items < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if ($urandom_range(49) == 0 && hi >= 60)
          len = $urandom_range(60, (hi < 200) ? hi : 200);
        else if ($urandom_range(99) < 85 && lo <= hi)
          len = $urandom_range(lo, (hi < lo + 11) ? hi : lo + 11);
        else
          len = $urandom_range(1, 20);
        send_key(len, -1);
        send_data($urandom_range(4, 40));
        if ($urandom_range(3) == 0) begin
          send_item(MODE_RESTART, 8'($urandom_range(255)), 1'($urandom_range(1)));
          send_data($urandom_range(2, 20));
        end
      end else begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No key yet, reset limits: data and restart report no key, mode 3 returns a zero byte with OK status
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_RESTART, 8'hFF, 1'b1);
    send_item(MODE_NONE, 8'hA5, 1'b1);
    send_item(MODE_DATA, 8'hFF, 1'b1);
    send_key(1, 8'h00);

    // Tight limits: shortest key, restart, too long a key, key at the maximum
    drain();
    set_limits(1, 3);
    send_key(1, 8'hFF);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'hFF, 1'b1);
    send_item(MODE_RESTART, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_NONE, 8'hFF, 1'b0);
    send_key(4, -1);
    send_item(MODE_DATA, 8'h5A, 1'b0);
    send_key(3, 8'h00);
    send_item(MODE_DATA, 8'hFF, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b1);

    // Full-size key, then one past the store so the count saturates
    drain();
    set_limits(512, 512);
    tx_idle_pct  = 29;
    rx_stall_pct = 29;
    send_key(512, -1);
    send_data(8);
    send_key(1030, -1);
    send_data(4);
    send_item(MODE_RESTART, 8'h3C, 1'b0);
    send_data(4);

    random_phase(0, 0, 1, 512, 3000);
    random_phase(65, 0, $urandom_range(1, 6), 511, 0);
    random_phase(0, 65, $urandom_range(1, 10), $urandom_range(1, 10), 0);
    random_phase(29, 29, 1, 1, 0);

    drain();
    repeat (1500) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS rc4_stream_cipher_unit");
    end else begin
      $display("FAIL rc4_stream_cipher_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
design/rc4s_pkg.sv
design/rc4s_perm_engine.sv
design/rc4_stream_cipher_unit.sv
tb/sv/tb.sv
